// File: sv/crs_pkg.sv
// Shared constants, types and helpers for the Catmull-Rom point stream.
// No dependencies.
package crs_pkg;

  localparam int CRS_MAX_SUBDIV  = 62;
  localparam int CRS_T_FRAC_BITS = 16;
  localparam int CRS_C_W         = 24;  // coordinate width
  localparam int CRS_W_W         = 6;   // subdivisions width
  localparam int CRS_D_W         = 7;   // divisor width, holds subdivisions + 1
  localparam int CRS_H_W         = 32;  // Horner accumulator width
  localparam int CRS_V_W         = 34;  // value plus offset before saturation
  localparam logic [CRS_W_W-1:0] CRS_SUBDIV_RST = 6'd4;

  typedef enum logic [1:0] {
    CFG_SUBDIV   = 2'd0,
    CFG_OFFSET_X = 2'd1,
    CFG_OFFSET_Y = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    IDLE_S,
    DSTART_S,
    DIV_S,
    MUL_S,
    EMIT_S,
    EMIT_W_S,
    EMIT_P_S,
    DONE_S
  } crs_state_e;

  localparam logic signed [CRS_V_W-1:0] CRS_SAT_MAX = 34'sd8388607;
  localparam logic signed [CRS_V_W-1:0] CRS_SAT_MIN = -34'sd8388608;

  function automatic logic [CRS_C_W-1:0] sat_add(logic signed [CRS_V_W-2:0] v,
                                                 logic signed [CRS_C_W-1:0] off);
    logic signed [CRS_V_W-1:0] s;
    s = CRS_V_W'(v) + CRS_V_W'(off);
    if (s > CRS_SAT_MAX) return CRS_SAT_MAX[CRS_C_W-1:0];
    if (s < CRS_SAT_MIN) return CRS_SAT_MIN[CRS_C_W-1:0];
    return s[CRS_C_W-1:0];
  endfunction

endpackage

// File: sv/catmull_rom_point_stream.sv
// Catmull-Rom point stream top level: sequencer, point window, output register.
// Depends on crs_pkg, crs_div, crs_mac.
//
// Control points enter one beat at a time; the block takes no new point until
// all beats caused by the current one are loaded into the output register.
// A point that closes a segment forms each interpolated sample in two parts:
// the shared divider forms t one quotient bit a cycle, then six
// multiply-round-add steps run through the one shared multiplier. Output
// back-pressure can hold the block in its emit states.
module catmull_rom_point_stream import crs_pkg::*; #(
  parameter int MAX_SUBDIVISIONS = CRS_MAX_SUBDIV,
  parameter int T_FRAC_BITS      = CRS_T_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CRS_C_W-1:0] cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,   // point_x, point_y
  input  logic               s_axis_tlast,   // final_point
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // out_x, out_y
  output logic               m_axis_tuser,   // is_control
  output logic               m_axis_tlast    // run_end
);
  localparam int NW = CRS_W_W + T_FRAC_BITS;
  localparam logic [CRS_W_W-1:0] MaxW = CRS_W_W'(MAX_SUBDIVISIONS);

  crs_state_e state_q, state_d;

  logic [CRS_W_W-1:0]        sub_q, w_q, k_q, w_clamp;
  logic signed [CRS_C_W-1:0] offx_q, offy_q, px_q, py_q;
  logic signed [CRS_C_W-1:0] wx_q [3];
  logic signed [CRS_C_W-1:0] wy_q [3];
  logic [1:0]                seen_q;
  logic                      fin_q;
  logic [2:0]                step_q;
  logic                      ph_q;
  logic signed [CRS_H_W-1:0] hx_q;

  logic               ov_q, octl_q, olast_q;
  logic [CRS_C_W-1:0] ox_q, oy_q;

  logic                      accept, free, div_start, div_done;
  logic                      mac_issue, mac_en2, ld, ld_ctl, ld_last;
  logic signed [CRS_V_W-2:0] ld_x, ld_y;
  logic [NW-1:0]             num;
  logic [CRS_D_W-1:0]        den;
  logic [T_FRAC_BITS:0]      u;
  logic signed [CRS_H_W-1:0] m_op, add_op, res;
  logic signed [CRS_H_W-1:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  logic signed [CRS_H_W-1:0] ax, bx, cx, dx, ay, by, cy, dy;

  assign w_clamp = (sub_q > MaxW) ? MaxW : sub_q;
  assign s_axis_tready = (state_q == IDLE_S);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign free   = !ov_q || m_axis_tready;

  assign den = CRS_D_W'(w_q) + 1'b1;
  assign num = NW'({k_q, {T_FRAC_BITS{1'b0}}}) + NW'(den >> 1);

  crs_div #(.NW(NW), .QW(T_FRAC_BITS + 1)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quot_o(u)
  );

  assign p0x = CRS_H_W'(wx_q[0]);
  assign p1x = CRS_H_W'(wx_q[1]);
  assign p2x = CRS_H_W'(wx_q[2]);
  assign p3x = CRS_H_W'(px_q);
  assign p0y = CRS_H_W'(wy_q[0]);
  assign p1y = CRS_H_W'(wy_q[1]);
  assign p2y = CRS_H_W'(wy_q[2]);
  assign p3y = CRS_H_W'(py_q);
  assign ax = p3x - p0x + 3 * (p1x - p2x);
  assign bx = 2 * p0x - 5 * p1x + 4 * p2x - p3x;
  assign cx = p2x - p0x;
  assign dx = 2 * p1x;
  assign ay = p3y - p0y + 3 * (p1y - p2y);
  assign by = 2 * p0y - 5 * p1y + 4 * p2y - p3y;
  assign cy = p2y - p0y;
  assign dy = 2 * p1y;

  always_comb begin
    case (step_q)
      3'd0: begin m_op = ax; add_op = bx; end
      3'd1: begin m_op = res; add_op = cx; end
      3'd2: begin m_op = res; add_op = dx; end
      3'd3: begin m_op = ay; add_op = by; end
      3'd4: begin m_op = res; add_op = cy; end
      default: begin m_op = res; add_op = dy; end
    endcase
  end

  crs_mac #(.T_FRAC_BITS(T_FRAC_BITS)) u_mac (
    .clk_i, .issue_i(mac_issue), .en2_i(mac_en2), .m_i(m_op), .u_i(u),
    .add_i(add_op), .res_o(res)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mac_issue = 1'b0;
    mac_en2   = 1'b0;
    ld        = 1'b0;
    ld_ctl    = 1'b1;
    ld_last   = 1'b1;
    ld_x      = (CRS_V_W-1)'(px_q);
    ld_y      = (CRS_V_W-1)'(py_q);
    case (state_q)
      IDLE_S: begin
        if (accept) begin
          if (seen_q == 2'd3) state_d = (w_clamp == '0) ? EMIT_W_S : DSTART_S;
          else if (seen_q == 2'd2 && !s_axis_tlast) state_d = DONE_S;
          else state_d = EMIT_P_S;
        end
      end
      DSTART_S: begin
        div_start = 1'b1;
        state_d   = DIV_S;
      end
      DIV_S: if (div_done) state_d = MUL_S;
      MUL_S: begin
        mac_issue = !ph_q;
        mac_en2   = ph_q;
        if (ph_q && step_q == 3'd5) state_d = EMIT_S;
      end
      EMIT_S: begin
        ld_x    = (CRS_V_W-1)'((CRS_V_W'(hx_q) + CRS_V_W'(1)) >>> 1);
        ld_y    = (CRS_V_W-1)'((CRS_V_W'(res) + CRS_V_W'(1)) >>> 1);
        ld_ctl  = 1'b0;
        ld_last = 1'b0;
        if (free) begin
          ld      = 1'b1;
          state_d = (k_q == w_q) ? EMIT_W_S : DSTART_S;
        end
      end
      EMIT_W_S: begin
        ld_x    = (CRS_V_W-1)'(wx_q[2]);
        ld_y    = (CRS_V_W-1)'(wy_q[2]);
        ld_last = !fin_q;
        if (free) begin
          ld      = 1'b1;
          state_d = fin_q ? EMIT_P_S : DONE_S;
        end
      end
      EMIT_P_S: begin
        if (free) begin
          ld      = 1'b1;
          state_d = DONE_S;
        end
      end
      DONE_S:  state_d = IDLE_S;
      default: state_d = IDLE_S;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= IDLE_S;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= CRS_SUBDIV_RST;
      offx_q <= '0;
      offy_q <= '0;
      seen_q <= '0;
      ov_q   <= 1'b0;
      step_q <= '0;
      ph_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wx_q[i] <= '0;
        wy_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SUBDIV:   sub_q  <= cfg_data_i[CRS_W_W-1:0];
          CFG_OFFSET_X: offx_q <= cfg_data_i;
          CFG_OFFSET_Y: offy_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ld) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (state_q == DIV_S) begin
        step_q <= '0;
        ph_q   <= 1'b0;
      end else if (state_q == MUL_S) begin
        ph_q <= !ph_q;
        if (ph_q) step_q <= step_q + 1'b1;
      end
      if (state_q == DONE_S) begin
        if (fin_q) begin
          seen_q <= '0;
          for (int i = 0; i < 3; i++) begin
            wx_q[i] <= '0;
            wy_q[i] <= '0;
          end
        end else begin
          wx_q[0] <= wx_q[1];
          wy_q[0] <= wy_q[1];
          wx_q[1] <= wx_q[2];
          wy_q[1] <= wy_q[2];
          wx_q[2] <= px_q;
          wy_q[2] <= py_q;
          if (seen_q != 2'd3) seen_q <= seen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q  <= s_axis_tdata[23:0];
      py_q  <= s_axis_tdata[47:24];
      fin_q <= s_axis_tlast;
      w_q   <= w_clamp;
      k_q   <= CRS_W_W'(1);
    end
    if (state_q == EMIT_S && free) k_q <= k_q + 1'b1;
    if (state_q == MUL_S && !ph_q && step_q == 3'd3) hx_q <= res;
    if (ld) begin
      ox_q    <= sat_add(ld_x, offx_q);
      oy_q    <= sat_add(ld_y, offy_q);
      octl_q  <= ld_ctl;
      olast_q <= ld_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {oy_q, ox_q};
  assign m_axis_tuser  = octl_q;
  assign m_axis_tlast  = olast_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == DIV_S) else $error("divider done outside wait");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("ready right after accept");
  a_last_is_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser) else $error("run ends on a sample");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MUL_S |-> step_q <= 3'd5) else $error("step out of range");

endmodule

// File: sv/crs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on crs_pkg.
module crs_div import crs_pkg::*; #(
  parameter int NW = CRS_W_W + CRS_T_FRAC_BITS,
  parameter int QW = CRS_T_FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW-1:0]      num_i,
  input  logic [CRS_D_W-1:0] den_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [CRS_D_W-1:0] rem_q, den_q;
  logic [NW-1:0]     n_q, q_q;
  logic [CRS_D_W:0]  trial;
  logic              fits;

  assign trial = {rem_q, n_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      n_q   <= num_i;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? CRS_D_W'(trial - {1'b0, den_q}) : trial[CRS_D_W-1:0];
      n_q   <= {n_q[NW-2:0], 1'b0};
      q_q   <= {q_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q[QW-1:0];

endmodule

// File: sv/crs_mac.sv
// Shared multiply, round and add unit: res = round(m * u / 2^T) + add.
// Two register stages. Depends on crs_pkg.
module crs_mac import crs_pkg::*; #(
  parameter int T_FRAC_BITS = CRS_T_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      issue_i,
  input  logic                      en2_i,
  input  logic signed [CRS_H_W-1:0] m_i,
  input  logic [T_FRAC_BITS:0]      u_i,
  input  logic signed [CRS_H_W-1:0] add_i,
  output logic signed [CRS_H_W-1:0] res_o
);
  localparam int PW = CRS_H_W + T_FRAC_BITS + 2;
  localparam logic signed [PW-1:0] Half = PW'(1) << (T_FRAC_BITS - 1);

  logic signed [T_FRAC_BITS+1:0] u_s;
  logic signed [PW-1:0]          prod_d, prod_q, rnd;
  logic signed [CRS_H_W-1:0]     add_q, rnd_part, res_q;

  assign u_s      = {1'b0, u_i};
  assign prod_d   = PW'(m_i) * PW'(u_s);
  assign rnd      = prod_q + Half;
  assign rnd_part = rnd[T_FRAC_BITS+CRS_H_W-1:T_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      add_q  <= add_i;
    end
    if (en2_i) res_q <= rnd_part + add_q;
  end

  assign res_o = res_q;

endmodule
